>>> sv/qmi_pkg.sv
// Shared types and codes for the queue with middle insertion.
// Holds operation and status codes, the controller state type and the result kind.
// No dependencies.
package qmi_pkg;

  // Operation codes carried by func.
  localparam logic [1:0] FUNC_APPEND     = 2'd0;
  localparam logic [1:0] FUNC_INSERT_MID = 2'd1;
  localparam logic [1:0] FUNC_POP        = 2'd2;

  // Status codes returned with a result.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Width of the id ports.
  localparam int unsigned PORT_ID_W = 16;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_MOVE
  } state_t;

  // Kind of result pending at the end of a request.
  typedef enum logic [1:0] {
    RES_NONE,
    RES_POP,
    RES_EMPTY,
    RES_FULL
  } res_t;

endpackage

>>> sv/qmi_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the front and back halves of the queue. No package dependencies.
module qmi_ram #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/queue_with_middle_insert.sv
// Queue with append, middle insert and pop, kept as two balanced ring buffers.
// A push that writes straight into one half leaves the block idle and ready; a pop, a
// refused request or a push that moves an entry between halves passes through the move
// state, set by the registered memory reads; results are registered on leaving that state.
// Synchronous reset clears pointers, counts and handshake state; the memories are
// not cleared, and only written entries are ever read.
// Depends on qmi_pkg and qmi_ram.
module queue_with_middle_insert #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned ID_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] entry_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] popped_id,
  output logic [1:0]  status
);

  localparam int unsigned HALF_DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned PTR_W = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HALF_DEPTH + 1);
  localparam int unsigned SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int unsigned TOT_W = CNT_W + 1;
  localparam int unsigned SW = (ID_WIDTH < qmi_pkg::PORT_ID_W) ? ID_WIDTH
                                                                : qmi_pkg::PORT_ID_W;

  // Ring pointer helpers.
  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(HALF_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(HALF_DEPTH - 1) : p - PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_at(input logic [PTR_W-1:0] h,
                                              input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(off);
    if (s >= SUM_W'(HALF_DEPTH)) begin
      s = s - SUM_W'(HALF_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  qmi_pkg::state_t state, state_next;

  logic [PTR_W-1:0] fh, fh_next, bh, bh_next;
  logic [CNT_W-1:0] fc, fc_next, bc, bc_next;
  qmi_pkg::res_t    res_kind, res_kind_next;
  logic             mv, mv_next;
  logic [PTR_W-1:0] move_addr;

  logic             accept, leave, full;
  logic [SW-1:0]    id_in;

  // Memory port signals.
  logic             f_we, f_re, b_we, b_re;
  logic [PTR_W-1:0] f_waddr, b_waddr, b_raddr;
  logic [SW-1:0]    f_wdata, f_rdata, b_rdata;
  logic             d_we;     // direct front write of the request id
  logic             d_we_mv;  // front write of a moved back entry

  assign accept = in_valid && in_ready;
  assign id_in  = SW'(entry_id);
  assign full   = (TOT_W'(fc) + TOT_W'(bc)) >= TOT_W'(CAPACITY);

  // Request decode: pointer and count updates, memory accesses, pending work.
  always_comb begin
    fh_next       = fh;
    bh_next       = bh;
    fc_next       = fc;
    bc_next       = bc;
    res_kind_next = qmi_pkg::RES_NONE;
    mv_next       = 1'b0;
    d_we          = 1'b0;
    f_re          = 1'b0;
    b_we          = 1'b0;
    b_re          = 1'b0;
    b_waddr       = ring_at(bh, bc);
    b_raddr       = bh;
    if (accept) begin
      case (func)
        qmi_pkg::FUNC_APPEND, qmi_pkg::FUNC_INSERT_MID: begin
          if (full) begin
            res_kind_next = qmi_pkg::RES_FULL;
          end else if (fc == bc) begin
            fc_next = fc + CNT_W'(1);
            if (func == qmi_pkg::FUNC_INSERT_MID || bc == '0) begin
              // The new id is itself the entry that crosses to the front half.
              d_we = 1'b1;
            end else begin
              b_we    = 1'b1;
              b_re    = 1'b1;
              bh_next = ring_inc(bh);
              mv_next = 1'b1;
            end
          end else begin
            b_we    = 1'b1;
            bc_next = bc + CNT_W'(1);
            if (func == qmi_pkg::FUNC_INSERT_MID) begin
              bh_next = ring_dec(bh);
              b_waddr = ring_dec(bh);
            end
          end
        end
        qmi_pkg::FUNC_POP: begin
          if (fc == '0) begin
            res_kind_next = qmi_pkg::RES_EMPTY;
          end else begin
            res_kind_next = qmi_pkg::RES_POP;
            f_re          = 1'b1;
            fh_next       = ring_inc(fh);
            if (bc == fc) begin
              b_re    = 1'b1;
              bh_next = ring_inc(bh);
              bc_next = bc - CNT_W'(1);
              mv_next = 1'b1;
            end else begin
              fc_next = fc - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      qmi_pkg::ST_IDLE: begin
        if (accept && (mv_next || res_kind_next != qmi_pkg::RES_NONE)) begin
          state_next = qmi_pkg::ST_MOVE;
        end
      end
      qmi_pkg::ST_MOVE: begin
        if (leave) begin
          state_next = qmi_pkg::ST_IDLE;
        end
      end
      default: state_next = qmi_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake and the deferred front write.
  always_comb begin
    in_ready = 1'b0;
    leave    = 1'b0;
    d_we_mv  = 1'b0;
    case (state)
      qmi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      qmi_pkg::ST_MOVE: begin
        leave   = (res_kind == qmi_pkg::RES_NONE) || !out_valid || out_ready;
        d_we_mv = leave && mv;
      end
      default: begin
      end
    endcase
  end

  // Front memory write port: direct id on a request, or the moved entry later.
  assign f_we    = d_we || d_we_mv;
  assign f_waddr = d_we_mv ? move_addr : ring_at(fh, fc);
  assign f_wdata = d_we_mv ? b_rdata : id_in;

  qmi_ram #(
    .DEPTH (HALF_DEPTH),
    .ADDR_W(PTR_W),
    .DATA_W(SW)
  ) u_front (
    .clk  (clk),
    .we   (f_we),
    .waddr(f_waddr),
    .wdata(f_wdata),
    .re   (f_re),
    .raddr(fh),
    .rdata(f_rdata)
  );

  qmi_ram #(
    .DEPTH (HALF_DEPTH),
    .ADDR_W(PTR_W),
    .DATA_W(SW)
  ) u_back (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(id_in),
    .re   (b_re),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= qmi_pkg::ST_IDLE;
      fh       <= '0;
      bh       <= '0;
      fc       <= '0;
      bc       <= '0;
      res_kind <= qmi_pkg::RES_NONE;
      mv       <= 1'b0;
    end else begin
      state <= state_next;
      fh    <= fh_next;
      bh    <= bh_next;
      fc    <= fc_next;
      bc    <= bc_next;
      if (accept) begin
        res_kind <= res_kind_next;
        mv       <= mv_next;
      end
    end
  end

  // The moved entry always lands at the front tail as it stood at the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      move_addr <= ring_at(fh, fc);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (leave && res_kind != qmi_pkg::RES_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (leave && res_kind != qmi_pkg::RES_NONE) begin
      case (res_kind)
        qmi_pkg::RES_POP: begin
          popped_id <= qmi_pkg::PORT_ID_W'(f_rdata);
          status    <= qmi_pkg::STATUS_OK;
        end
        qmi_pkg::RES_EMPTY: begin
          popped_id <= '0;
          status    <= qmi_pkg::STATUS_EMPTY;
        end
        default: begin
          popped_id <= '0;
          status    <= qmi_pkg::STATUS_FULL;
        end
      endcase
    end
  end

  // The front half holds the extra entry when the length is odd, never more.
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (fc == bc) || (fc == bc + CNT_W'(1)))
    else $error("queue halves out of balance");

  // The two halves together never exceed the capacity.
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    (TOT_W'(fc) + TOT_W'(bc)) <= TOT_W'(CAPACITY))
    else $error("queue length exceeds capacity");

  // Every accepted pop produces a result, so it must pass through the move state.
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (accept && func == qmi_pkg::FUNC_POP) |=> (state == qmi_pkg::ST_MOVE))
    else $error("pop request did not schedule a result");

endmodule

>>> tb/tb_queue_with_middle_insert.sv
// Self-checking testbench for the queue with append, middle insert and pop at the head.
// Mirrors the two balanced halves in a scoreboard class and drives both handshakes at random.
// Depends on qmi_pkg and the queue_with_middle_insert top level.
module tb_queue_with_middle_insert;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_CAPACITY = 1024;
  localparam int unsigned HALF_DEPTH     = (QUEUE_CAPACITY + 1) / 2;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES    = 10;
  // The fourth selector value has no operation behind it.
  localparam logic [1:0]  FUNC_UNUSED    = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  status;
  } qmi_result_t;

  // Scoreboard: a copy of the two ring halves plus the results still owed.
  class qmi_scoreboard;
    logic [15:0] front_mem [HALF_DEPTH];
    logic [15:0] back_mem  [HALF_DEPTH];
    logic [8:0]  front_head = '0;
    logic [8:0]  back_head  = '0;
    int unsigned front_cnt  = 0;
    int unsigned back_cnt   = 0;
    qmi_result_t awaited [$];
    int unsigned errors = 0, checked = 0, peak = 0;
    int unsigned n_push = 0, n_pop = 0, n_ignored = 0;
    int unsigned n_ok = 0, n_empty = 0, n_full = 0;

    function int unsigned queue_length();
      return front_cnt + back_cnt;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // Move the back half's head onto the front half's tail when the back half is larger.
    function void rebalance();
      logic [8:0] slot;
      if (back_cnt > front_cnt) begin
        slot = front_head + 9'(front_cnt);
        front_mem[slot] = back_mem[back_head];
        back_head = back_head + 9'd1;
        back_cnt--;
        front_cnt++;
      end
    endfunction

    // Apply one accepted request and queue the result it owes, if any.
    function void note_request(logic [1:0] op, logic [15:0] id);
      logic [8:0]  slot;
      qmi_result_t res;
      case (op)
        qmi_pkg::FUNC_APPEND, qmi_pkg::FUNC_INSERT_MID: begin
          n_push++;
          if (queue_length() >= QUEUE_CAPACITY) begin
            res = '{id: '0, status: qmi_pkg::STATUS_FULL};
            awaited = {awaited, res};
            n_full++;
          end else begin
            if (op == qmi_pkg::FUNC_APPEND) begin
              slot = back_head + 9'(back_cnt);
              back_mem[slot] = id;
            end else begin
              // A middle insert is a push at the head of the back half.
              back_head = back_head - 9'd1;
              back_mem[back_head] = id;
            end
            back_cnt++;
            rebalance();
            if (queue_length() > peak) peak = queue_length();
          end
        end
        qmi_pkg::FUNC_POP: begin
          n_pop++;
          if (front_cnt == 0) begin
            res = '{id: '0, status: qmi_pkg::STATUS_EMPTY};
            n_empty++;
          end else begin
            res = '{id: front_mem[front_head], status: qmi_pkg::STATUS_OK};
            front_head = front_head + 9'd1;
            front_cnt--;
            rebalance();
            n_ok++;
          end
          awaited = {awaited, res};
        end
        default: n_ignored++;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest one owed.
    task check_result(logic [15:0] got_id, logic [1:0] got_status);
      qmi_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result id %h status %0d with nothing owed",
                                  got_id, got_status));
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      if (got_status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
      if (got_id !== want.id)
        report_mismatch($sformatf("popped_id %h, expected %h", got_id, want.id));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [15:0] entry_id;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] popped_id;
  logic [1:0]  status;

  qmi_scoreboard sb = new();
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  int unsigned   rx_hold = 0;

  queue_with_middle_insert #(
    .CAPACITY(QUEUE_CAPACITY),
    .ID_WIDTH(16)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .entry_id(entry_id),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .popped_id(popped_id),
    .status(status)
  );

  // Clock with an 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one request, idling at random first, and record it once accepted.
  task automatic send_request(input logic [1:0] op, input logic [15:0] id);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    func     = op;
    entry_id = id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, id);
  endtask

  // Draw a random request with the given shares of pushes and pops; the rest are ignored.
  task automatic send_random(input int unsigned push_pct, input int unsigned pop_pct);
    int unsigned pick;
    logic [1:0]  op;
    pick = $urandom_range(99);
    if (pick < push_pct)
      op = $urandom_range(1) ? qmi_pkg::FUNC_INSERT_MID : qmi_pkg::FUNC_APPEND;
    else if (pick < push_pct + pop_pct)
      op = qmi_pkg::FUNC_POP;
    else
      op = FUNC_UNUSED;
    send_request(op, 16'($urandom_range(16'hFFFF)));
  endtask

  // Result side: ready changes at the falling edge, with an occasional long hold-off.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold != 0) begin
        out_ready = 1'b0;
        rx_hold--;
      end else begin
        out_ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Results are checked at the rising edge on which they are taken.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(popped_id, status);
    end
  end

  // Watchdog: give up after a long run of cycles with no handshake on either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] timeout: no handshake for %0d cycles", $realtime, STALL_LIMIT);
    $display("** queue_with_middle_insert: FAILED **");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    func     = qmi_pkg::FUNC_APPEND;
    entry_id = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed requests: empty pops, the unused selector, id extremes, both push kinds.
    tx_idle_pct = 22;
    rx_idle_pct = 53;
    send_request(qmi_pkg::FUNC_POP, 16'h0000);
    send_request(FUNC_UNUSED, 16'h0000);
    send_request(qmi_pkg::FUNC_APPEND, 16'h0000);
    send_request(qmi_pkg::FUNC_APPEND, 16'hFFFF);
    send_request(qmi_pkg::FUNC_INSERT_MID, 16'h1234);
    send_request(qmi_pkg::FUNC_INSERT_MID, 16'hA5A5);
    send_request(qmi_pkg::FUNC_APPEND, 16'h5A5A);
    send_request(FUNC_UNUSED, 16'hFFFF);
    repeat (5) send_request(qmi_pkg::FUNC_POP, 16'hFFFF);
    send_request(qmi_pkg::FUNC_POP, 16'h0000);
    send_request(qmi_pkg::FUNC_INSERT_MID, 16'h8001);
    send_request(qmi_pkg::FUNC_INSERT_MID, 16'h7FFE);
    send_request(qmi_pkg::FUNC_INSERT_MID, 16'h0001);
    repeat (3) send_request(qmi_pkg::FUNC_POP, 16'h0000);

    // Mixed traffic around a short queue, where empty pops come up often.
    repeat (100) send_random(50, 45);

    // Swap the idling sides and fill the queue to capacity.
    tx_idle_pct = 53;
    rx_idle_pct = 22;
    while (sb.queue_length() < QUEUE_CAPACITY) send_random(94, 4);

    // At capacity, stop taking results for a while so the block backs up onto its input.
    rx_hold = RX_HOLD_CYCLES;
    repeat (40) send_random(60, 40);

    // Pause the sender until every owed result has been taken.
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    // No idling on either side, mostly pops.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (80) send_random(35, 60);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d pushes, %0d pops and %0d ignored requests; peak length %0d of %0d.",
             sb.n_push, sb.n_pop, sb.n_ignored, sb.peak, QUEUE_CAPACITY);
    $display("Checked %0d results (%0d popped, %0d empty, %0d refused full), %0d mismatches.",
             sb.checked, sb.n_ok, sb.n_empty, sb.n_full, sb.errors);
    if (sb.errors == 0) begin
      $display("** queue_with_middle_insert: PASSED **");
    end else begin
      $display("** queue_with_middle_insert: FAILED **");
    end
    $finish;
  end

endmodule
